>>> rtl/core/bdsl_pkg.sv
// ----------------------------------------------------------------------------
// bdsl_pkg
// Shared types, codes and the edge priority table for the button debouncer.
// ----------------------------------------------------------------------------
package bdsl_pkg;

    localparam int LEVEL_W    = 6;
    localparam int BUTTON_W   = 3;
    localparam int EVENT_W    = 2;
    localparam int COUNT_W    = 16;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    // Register indexes on the configuration port
    localparam logic REG_DEBOUNCE = 1'b0;
    localparam logic REG_LONG     = 1'b1;

    // Reset values of the configuration registers
    localparam logic [COUNT_W-1:0] DEBOUNCE_RESET = 16'd50;
    localparam logic [COUNT_W-1:0] LONG_RESET     = 16'd1000;

    typedef enum logic [EVENT_W-1:0] {
        EV_PRESS = 2'd0,
        EV_LONG  = 2'd1,
        EV_SHORT = 2'd2
    } ev_code_t;

    // Rising edge found in one beat
    typedef struct packed {
        logic                hit;
        logic [BUTTON_W-1:0] button;
    } edge_t;

    // Result of one beat from the control logic
    typedef struct packed {
        logic                valid;
        logic [BUTTON_W-1:0] button;
        ev_code_t            event_res;
    } result_t;

    // Edge priority, highest first: center, left, blue, down, right, up
    localparam logic [BUTTON_W-1:0] PRIORITY_ORDER [8] = '{
        3'd4, 3'd3, 3'd5, 3'd2, 3'd1, 3'd0, 3'd7, 3'd6
    };

    // Pick the winning rising edge; scan lowest priority first so the
    // highest priority hit overwrites the others
    function automatic edge_t pick_edge(input logic [LEVEL_W-1:0] rise,
                                        input int count);
        edge_t             res;
        logic [7:0]        rise_ext;
        logic [BUTTON_W-1:0] b;
        res      = '0;
        rise_ext = 8'(rise);
        for (int i = 7; i >= 0; i--)
        begin
            b = PRIORITY_ORDER[i];
            if ((int'(b) < count) && rise_ext[b])
            begin
                res.hit    = 1'b1;
                res.button = b;
            end
        end
        return res;
    endfunction

endpackage

>>> rtl/core/bdsl_sample_if.sv
// ----------------------------------------------------------------------------
// bdsl_sample_if
// Input channel: one beat carries the raw button levels of one tick.
// ----------------------------------------------------------------------------
interface bdsl_sample_if;
    import bdsl_pkg::*;

    logic               valid;
    logic               ready;
    logic [LEVEL_W-1:0] button_levels;

    modport source (output valid, output button_levels, input ready);
    modport sink   (input valid, input button_levels, output ready);
endinterface

>>> rtl/core/bdsl_result_if.sv
// ----------------------------------------------------------------------------
// bdsl_result_if
// Output channel: one beat carries a tracked button and its event code.
// ----------------------------------------------------------------------------
interface bdsl_result_if;
    import bdsl_pkg::*;

    logic                valid;
    logic                ready;
    logic [BUTTON_W-1:0] button;
    logic [EVENT_W-1:0]  event_res;

    modport source (output valid, output button, output event_res, input ready);
    modport sink   (input valid, input button, input event_res, output ready);
endinterface

>>> rtl/core/bdsl_edge.sv
// ----------------------------------------------------------------------------
// bdsl_edge
// Rising edge detector with fixed button priority; holds the last levels.
// ----------------------------------------------------------------------------
module bdsl_edge #(
    parameter int BUTTON_COUNT = 6
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     step,
    input  logic [bdsl_pkg::LEVEL_W-1:0] levels_raw,
    output logic [bdsl_pkg::LEVEL_W-1:0] levels,
    output bdsl_pkg::edge_t          edge_info
);
    import bdsl_pkg::*;

    localparam int MASK_W = (BUTTON_COUNT < LEVEL_W) ? BUTTON_COUNT : LEVEL_W;
    localparam logic [LEVEL_W-1:0] LEVEL_MASK = LEVEL_W'((1 << MASK_W) - 1);

    logic [LEVEL_W-1:0] prev_levels_reg;
    logic [LEVEL_W-1:0] rise;

    // Drop levels of buttons that do not exist
    assign levels    = levels_raw & LEVEL_MASK;
    assign rise      = levels & ~prev_levels_reg;
    assign edge_info = pick_edge(rise, BUTTON_COUNT);

    // Hold the levels of the last processed tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_levels_reg <= '0;
        end
        else if (step)
        begin
            prev_levels_reg <= levels;
        end
    end
endmodule

>>> rtl/core/bdsl_ctrl.sv
// ----------------------------------------------------------------------------
// bdsl_ctrl
// Press sequencer: debounce wait, long timer and release handling per tick.
// ----------------------------------------------------------------------------
module bdsl_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         step,
    input  logic [bdsl_pkg::LEVEL_W-1:0] levels,
    input  bdsl_pkg::edge_t              edge_info,
    input  logic [bdsl_pkg::COUNT_W-1:0] debounce_ticks,
    input  logic [bdsl_pkg::COUNT_W-1:0] long_press_ticks,
    output bdsl_pkg::result_t            res
);
    import bdsl_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRESS_WAIT,
        ST_PRESSED,
        ST_LONG,
        ST_RELEASE_WAIT
    } state_t;

    state_t              state_reg,    state_next;
    logic [BUTTON_W-1:0] tracked_reg,  tracked_next;
    logic [COUNT_W-1:0]  deb_reg,      deb_next;
    logic [COUNT_W-1:0]  long_reg,     long_next;
    logic                running_reg,  running_next;

    logic [COUNT_W-1:0]  long_dec;
    logic [COUNT_W-1:0]  deb_dec;
    logic                deb_done;
    logic                held;
    logic [7:0]          levels_ext;

    // Tracked button follows every edge; long timer and debounce step down
    always_comb
    begin
        tracked_next = edge_info.hit ? edge_info.button : tracked_reg;
        long_dec     = (running_reg && (long_reg != '0)) ? long_reg - 1'b1 : long_reg;
        deb_done     = (deb_reg <= COUNT_W'(1));
        deb_dec      = deb_done ? '0 : deb_reg - 1'b1;
        levels_ext   = 8'(levels);
        held         = levels_ext[tracked_next];
    end

    // Advance the phase for one tick
    always_comb
    begin
        state_next    = state_reg;
        deb_next      = deb_reg;
        long_next     = long_reg;
        running_next  = running_reg;
        res.valid     = 1'b0;
        res.button    = tracked_next;
        res.event_res = EV_PRESS;
        if (state_reg != ST_IDLE)
        begin
            long_next = long_dec;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (edge_info.hit)
                begin
                    long_next    = long_press_ticks;
                    running_next = 1'b1;
                    deb_next     = debounce_ticks;
                    state_next   = ST_PRESS_WAIT;
                end
            end
            ST_PRESS_WAIT:
            begin
                deb_next = deb_dec;
                if (deb_done)
                begin
                    state_next = ST_PRESSED;
                    res.valid  = 1'b1;
                end
            end
            ST_PRESSED:
            begin
                if (running_reg && (long_dec == '0))
                begin
                    running_next  = 1'b0;
                    state_next    = ST_LONG;
                    res.valid     = 1'b1;
                    res.event_res = EV_LONG;
                end
                else if (!held)
                begin
                    running_next  = 1'b0;
                    long_next     = '0;
                    deb_next      = debounce_ticks;
                    state_next    = ST_RELEASE_WAIT;
                    res.valid     = 1'b1;
                    res.event_res = EV_SHORT;
                end
            end
            ST_LONG:
            begin
                if (!held)
                begin
                    deb_next   = debounce_ticks;
                    state_next = ST_RELEASE_WAIT;
                end
            end
            ST_RELEASE_WAIT:
            begin
                deb_next = deb_dec;
                if (deb_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and counters; update once per processed tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            tracked_reg <= '0;
            deb_reg     <= '0;
            long_reg    <= '0;
            running_reg <= 1'b0;
        end
        else if (step)
        begin
            state_reg   <= state_next;
            tracked_reg <= tracked_next;
            deb_reg     <= deb_next;
            long_reg    <= long_next;
            running_reg <= running_next;
        end
    end
endmodule

>>> rtl/core/button_debounce_short_long_press.sv
// ----------------------------------------------------------------------------
// button_debounce_short_long_press
// Button debouncer with press, long press and short release events.
// ----------------------------------------------------------------------------
// One tick of button levels is taken per clock cycle. An accepted beat sits in
// the input register, where the edge detector and the press sequencer
// process it; its event (if any) is loaded into the result register when
// the beat moves on, and is offered on the result channel from there. The
// input side stalls only while the result register holds an event not yet
// taken and the input register is full. Registers at byte 0 (debounce_ticks)
// and 4 (long_press_ticks) are written over the APB port; the user must do
// so only while the block is idle, as the block itself does not enforce it.
module button_debounce_short_long_press #(
    parameter int BUTTON_COUNT = 6
) (
    input  logic                            clk,
    input  logic                            rst_n,
    bdsl_sample_if.sink                     sample,
    bdsl_result_if.source                   result,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [bdsl_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [bdsl_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [bdsl_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready
);
    import bdsl_pkg::*;

    logic               s1_valid_reg;
    logic [LEVEL_W-1:0] s1_levels_reg;
    logic               s1_advance;

    logic [LEVEL_W-1:0] levels;
    edge_t              edge_info;
    result_t            res;

    logic                out_valid_reg;
    logic [BUTTON_W-1:0] out_button_reg;
    logic [EVENT_W-1:0]  out_event_reg;

    logic [COUNT_W-1:0] debounce_reg;
    logic [COUNT_W-1:0] long_reg;
    logic               cfg_write;

    // Configuration registers
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= DEBOUNCE_RESET;
            long_reg     <= LONG_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                REG_DEBOUNCE: debounce_reg <= pwdata[COUNT_W-1:0];
                REG_LONG:     long_reg     <= pwdata[COUNT_W-1:0];
                default:      debounce_reg <= debounce_reg;
            endcase
        end
    end

    // Read back the addressed register
    always_comb
    begin
        unique case (paddr[2])
            REG_DEBOUNCE: prdata = CFG_DATA_W'(debounce_reg);
            REG_LONG:     prdata = CFG_DATA_W'(long_reg);
            default:      prdata = '0;
        endcase
    end

    // Input register: move on when the result register can take the beat
    assign s1_advance   = s1_valid_reg && (!out_valid_reg || result.ready);
    assign sample.ready = !s1_valid_reg || s1_advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (sample.valid && sample.ready)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample.valid && sample.ready)
        begin
            s1_levels_reg <= sample.button_levels;
        end
    end

    bdsl_edge #(
        .BUTTON_COUNT (BUTTON_COUNT)
    ) u_edge (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (s1_advance),
        .levels_raw (s1_levels_reg),
        .levels     (levels),
        .edge_info  (edge_info)
    );

    bdsl_ctrl u_ctrl (
        .clk              (clk),
        .rst_n            (rst_n),
        .step             (s1_advance),
        .levels           (levels),
        .edge_info        (edge_info),
        .debounce_ticks   (debounce_reg),
        .long_press_ticks (long_reg),
        .res              (res)
    );

    // Result register: load on each processed tick, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_advance)
        begin
            out_valid_reg <= res.valid;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance && res.valid)
        begin
            out_button_reg <= res.button;
            out_event_reg  <= res.event_res;
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.button    = out_button_reg;
    assign result.event_res = out_event_reg;
endmodule

>>> rtl/core/bdsl_checker.sv
// ----------------------------------------------------------------------------
// bdsl_checker
// Port-level checks of the button debouncer, bound to the top level.
// ----------------------------------------------------------------------------
module bdsl_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          result_valid,
    input logic                          result_ready,
    input logic [bdsl_pkg::BUTTON_W-1:0] result_button,
    input logic [bdsl_pkg::EVENT_W-1:0]  result_event_res,
    input logic                          pready
);
    import bdsl_pkg::*;

    // A stalled result beat holds its payload
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            result_valid && $stable(result_button) && $stable(result_event_res))
        else $error("result beat changed while stalled");

    // Only press, long and short codes leave the block
    a_event_code: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result_event_res == EV_PRESS) ||
                         (result_event_res == EV_LONG)  ||
                         (result_event_res == EV_SHORT))
        else $error("unknown event code");

    // Tracked button stays within the six buttons
    a_button_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result_button <= BUTTON_W'(5)))
        else $error("button index out of range");

    // Configuration port never inserts wait states
    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready low");
endmodule

bind button_debounce_short_long_press bdsl_checker u_bdsl_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .result_valid     (result.valid),
    .result_ready     (result.ready),
    .result_button    (result.button),
    .result_event_res (result.event_res),
    .pready           (pready)
);

>>> tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the button debouncer against a cycle-free model of its press
// sequencer. Ticks of button levels go in over the sample channel; each
// press, long and short event that comes out is compared with the model's
// prediction. Timing registers are set over APB between phases, including
// zero and full-scale values. Random sequences then run under three
// patterns of input gaps and output stalls.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import bdsl_pkg::*;

    localparam int DRAIN_LIMIT   = 20000;
    localparam int SETTLE_CYCLES = 6;
    localparam int MAX_REPORTS   = 10;

    // Sequencer phases of the model
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRESS_WAIT,
        ST_PRESSED,
        ST_LONG,
        ST_RELEASE_WAIT
    } press_state_t;

    typedef struct packed {
        logic [BUTTON_W-1:0] button;
        ev_code_t            ev;
    } press_event_t;

    // Edge priority, strongest first: center, left, blue, down, right, up
    localparam logic [BUTTON_W-1:0] PRESS_RANK [6] = '{
        3'd4, 3'd3, 3'd5, 3'd2, 3'd1, 3'd0
    };

    logic clk;
    logic rst_n;

    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    bdsl_sample_if sample_ch ();
    bdsl_result_if result_ch ();

    button_debounce_short_long_press #(
        .BUTTON_COUNT (6)
    ) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .sample  (sample_ch),
        .result  (result_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Model state and timing registers
    press_state_t        ph;
    logic [BUTTON_W-1:0] trk;
    logic [LEVEL_W-1:0]  prev_lv;
    logic [COUNT_W-1:0]  deb_cnt;
    logic [COUNT_W-1:0]  long_cnt;
    logic                long_armed;
    logic [COUNT_W-1:0]  cfg_debounce;
    logic [COUNT_W-1:0]  cfg_long;

    press_event_t expected_events [$];

    int src_idle_pct;
    int snk_idle_pct;
    int errors;
    int ticks_sent;
    int reg_writes;
    int events_seen [3];

    // ------------------------------------------------------------------
    // Clock and run limit
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    initial
    begin
        #12_000_000;
        $display("testbench: done, errors");
        $finish;
    end

    // Stall the result channel at random
    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            result_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    function automatic void note_error(input string msg);
        errors++;
        if (errors <= MAX_REPORTS)
        begin
            $display("ERROR: %s", msg);
        end
    endfunction

    // ------------------------------------------------------------------
    // Press sequencer model
    // ------------------------------------------------------------------
    function automatic void reset_model();
        ph           = ST_IDLE;
        trk          = '0;
        prev_lv      = '0;
        deb_cnt      = '0;
        long_cnt     = '0;
        long_armed   = 1'b0;
        cfg_debounce = DEBOUNCE_RESET;
        cfg_long     = LONG_RESET;
    endfunction

    // Count the debounce wait down; a count of zero finishes like one
    function automatic logic debounce_done();
        if (deb_cnt > 1)
        begin
            deb_cnt = deb_cnt - 1'b1;
            return 1'b0;
        end
        deb_cnt = '0;
        return 1'b1;
    endfunction

    function automatic void push_event(input ev_code_t ev);
        press_event_t pe;
        pe.button = trk;
        pe.ev     = ev;
        expected_events.push_back(pe);
    endfunction

    function automatic void predict_tick(input logic [LEVEL_W-1:0] lv);
        logic [LEVEL_W-1:0] rise;
        logic               hit;
        logic               held;
        rise    = lv & ~prev_lv;
        prev_lv = lv;
        hit     = 1'b0;

        // Track the strongest rising edge
        for (int i = 0; i < 6; i++)
        begin
            if (!hit && rise[PRESS_RANK[i]])
            begin
                trk = PRESS_RANK[i];
                hit = 1'b1;
            end
        end

        if (ph == ST_IDLE)
        begin
            if (hit)
            begin
                long_cnt   = cfg_long;
                long_armed = 1'b1;
                deb_cnt    = cfg_debounce;
                ph         = ST_PRESS_WAIT;
            end
            return;
        end

        if (long_armed && long_cnt != 0)
        begin
            long_cnt = long_cnt - 1'b1;
        end
        held = lv[trk];

        case (ph)
            ST_PRESS_WAIT:
            begin
                if (debounce_done())
                begin
                    ph = ST_PRESSED;
                    push_event(EV_PRESS);
                end
            end
            ST_PRESSED:
            begin
                // An expired long timer wins over the release check
                if (long_armed && long_cnt == 0)
                begin
                    long_armed = 1'b0;
                    ph         = ST_LONG;
                    push_event(EV_LONG);
                end
                else if (!held)
                begin
                    long_armed = 1'b0;
                    long_cnt   = '0;
                    deb_cnt    = cfg_debounce;
                    ph         = ST_RELEASE_WAIT;
                    push_event(EV_SHORT);
                end
            end
            ST_LONG:
            begin
                if (!held)
                begin
                    deb_cnt = cfg_debounce;
                    ph      = ST_RELEASE_WAIT;
                end
            end
            ST_RELEASE_WAIT:
            begin
                if (debounce_done())
                begin
                    ph = ST_IDLE;
                end
            end
            default:
            begin
                ph = ST_IDLE;
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Result checker: compare each taken beat with the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : check_results
        press_event_t want;
        if (rst_n === 1'b1 && result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
        begin
            if (expected_events.size() == 0)
            begin
                note_error($sformatf("unexpected event: button %0d event %0d",
                                     result_ch.button, result_ch.event_res));
            end
            else
            begin
                want = expected_events.pop_front();
                events_seen[int'(want.ev)]++;
                if (result_ch.button !== want.button ||
                    result_ch.event_res !== want.ev)
                begin
                    note_error($sformatf(
                        "event mismatch: expected button %0d event %0d, got %0d/%0d",
                        want.button, want.ev, result_ch.button, result_ch.event_res));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Channel and register access
    // ------------------------------------------------------------------
    task automatic send_tick(input logic [LEVEL_W-1:0] lv);
        // Insert random gaps before the beat
        while ($urandom_range(99) < src_idle_pct)
        begin
            sample_ch.valid <= 1'b0;
            @(posedge clk);
        end
        sample_ch.valid         <= 1'b1;
        sample_ch.button_levels <= lv;
        do
        begin
            @(posedge clk);
        end
        while (sample_ch.ready !== 1'b1);
        predict_tick(lv);
        ticks_sent++;
    endtask

    task automatic hold_levels(input logic [LEVEL_W-1:0] lv, input int n);
        repeat (n)
        begin
            send_tick(lv);
        end
    endtask

    // Release everything until the sequencer is back in idle
    task automatic flush_to_idle();
        while (ph != ST_IDLE)
        begin
            send_tick('0);
        end
    endtask

    // Stop sending, wait for the outstanding events, then let the pipe settle
    task automatic drain_results();
        int guard;
        guard = 0;
        sample_ch.valid <= 1'b0;
        while (expected_events.size() != 0 && guard < DRAIN_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (SETTLE_CYCLES)
        begin
            @(posedge clk);
        end
    endtask

    function automatic logic [CFG_ADDR_W-1:0] reg_addr(input logic idx);
        return CFG_ADDR_W'(4 * int'(idx));
    endfunction

    task automatic write_reg(input logic idx, input logic [COUNT_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= reg_addr(idx);
        pwdata  <= CFG_DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        if (idx == REG_DEBOUNCE)
        begin
            cfg_debounce = value;
        end
        else
        begin
            cfg_long = value;
        end
        reg_writes++;
    endtask

    task automatic check_reg(input logic idx);
        logic [CFG_DATA_W-1:0] got;
        logic [CFG_DATA_W-1:0] want;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= reg_addr(idx);
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (pready !== 1'b1);
        got     = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        want = (idx == REG_DEBOUNCE) ? CFG_DATA_W'(cfg_debounce) : CFG_DATA_W'(cfg_long);
        if (got !== want)
        begin
            note_error($sformatf("register %0d readback: expected %0d, got %0d",
                                 idx, want, got));
        end
    endtask

    // Bring the block to idle, then load both timing registers
    task automatic set_timing(input logic [COUNT_W-1:0] deb, input logic [COUNT_W-1:0] lng);
        flush_to_idle();
        drain_results();
        write_reg(REG_DEBOUNCE, deb);
        write_reg(REG_LONG, lng);
        check_reg(REG_DEBOUNCE);
        check_reg(REG_LONG);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_register_defaults();
        check_reg(REG_DEBOUNCE);
        check_reg(REG_LONG);
    endtask

    // Short press at the reset timing
    task automatic test_default_timing();
        hold_levels(6'h01, 60);
        flush_to_idle();
    endtask

    // Each pattern but the last leaves a different button as the strongest edge
    task automatic test_edge_priority();
        logic [LEVEL_W-1:0] patterns [7];
        patterns = '{6'h3F, 6'h2F, 6'h27, 6'h07, 6'h03, 6'h01, 6'h10};
        set_timing(16'd2, 16'd10);
        foreach (patterns[i])
        begin
            send_tick(patterns[i]);
            flush_to_idle();
        end
    endtask

    // Edges while busy only move the tracked button
    task automatic test_retrack_while_busy();
        set_timing(16'd3, 16'd20);
        send_tick(6'h01);
        hold_levels(6'h03, 3);
        send_tick(6'h01);
        send_tick(6'h21);
        flush_to_idle();
        hold_levels(6'h04, 25);
        send_tick(6'h0C);
        send_tick(6'h04);
        flush_to_idle();
    endtask

    // Long timer runs out inside the debounce wait
    task automatic test_long_before_press();
        set_timing(16'd6, 16'd2);
        send_tick(6'h10);
        flush_to_idle();
    endtask

    task automatic test_zero_timing();
        set_timing(16'd0, 16'd0);
        hold_levels(6'h04, 3);
        flush_to_idle();
    endtask

    // Full-scale debounce is checked through the registers; a full-scale
    // long timer must still let a quick release through as short
    task automatic test_timing_extremes();
        set_timing(16'hFFFF, 16'd1);
        set_timing(16'd1, 16'hFFFF);
        hold_levels(6'h20, 4);
        flush_to_idle();
    endtask

    // Mostly clean press/hold/release sequences, some chatter and noise
    task automatic test_random_mix(input int src_pct, input int snk_pct,
                                   input int deb_max, input int long_max, input int n);
        int                 sent;
        int                 kind;
        int                 b;
        int                 hold;
        int                 gap;
        logic [LEVEL_W-1:0] lv;
        set_timing(COUNT_W'($urandom_range(deb_max, 1)),
                   COUNT_W'($urandom_range(long_max, 1)));
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        sent         = 0;
        while (sent < n)
        begin
            kind = $urandom_range(99);
            b    = $urandom_range(5);
            hold = $urandom_range(int'(cfg_debounce) + int'(cfg_long) + 4, 1);
            gap  = $urandom_range(int'(cfg_debounce) + 3, 0);
            if (kind < 85)
            begin
                for (int k = 0; k < hold + gap; k++)
                begin
                    lv = (k < hold) ? LEVEL_W'(1 << b) : '0;
                    // Chatter on other buttons and bounce on the held one
                    if (kind >= 65 && $urandom_range(3) == 0)
                    begin
                        lv = lv | LEVEL_W'($urandom);
                    end
                    if (kind >= 65 && $urandom_range(5) == 0)
                    begin
                        lv[b] = 1'b0;
                    end
                    sent++;
                    send_tick(lv);
                end
            end
            else
            begin
                repeat ($urandom_range(8, 1))
                begin
                    lv = LEVEL_W'($urandom);
                    sent++;
                    send_tick(lv);
                end
            end
        end
        flush_to_idle();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n                   = 1'b0;
        sample_ch.valid         = 1'b0;
        sample_ch.button_levels = '0;
        psel                    = 1'b0;
        penable                 = 1'b0;
        pwrite                  = 1'b0;
        paddr                   = '0;
        pwdata                  = '0;
        src_idle_pct            = 0;
        snk_idle_pct            = 0;
        errors                  = 0;
        ticks_sent              = 0;
        reg_writes              = 0;
        events_seen             = '{0, 0, 0};
        reset_model();

        repeat (11)
        begin
            @(posedge clk);
        end
        rst_n <= 1'b1;
        @(posedge clk);

        test_register_defaults();
        test_default_timing();
        test_edge_priority();
        test_retrack_while_busy();
        test_long_before_press();
        test_zero_timing();
        test_timing_extremes();
        test_random_mix(32, 80, 6, 15, 120);
        test_random_mix(80, 32, 3, 8, 120);
        test_random_mix(0, 0, 8, 20, 120);

        drain_results();
        while (expected_events.size() != 0)
        begin
            void'(expected_events.pop_front());
            note_error("predicted event never arrived");
        end

        $display("summary: %0d ticks, %0d register writes, %0d errors",
                 ticks_sent, reg_writes, errors);
        $display("summary: events checked: %0d press, %0d long, %0d short",
                 events_seen[0], events_seen[1], events_seen[2]);
        if (errors == 0)
        begin
            $display("testbench: done, clean");
        end
        else
        begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
